[rtl/spv_pkg.sv]
`default_nettype none
package spv_pkg;

   // Sample word width; the payload sample fields are sized to it
   localparam int SAMPLE_BITS = 16;

   // Command codes of an input item
   localparam logic [1:0] CMD_LOAD     = 2'd0;
   localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
   localparam logic [1:0] CMD_NOTE_OFF = 2'd2;
   localparam logic [1:0] CMD_TICK     = 2'd3;

   // Register file
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_NOTE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_RATIO      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_LENGTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_SAMPLES  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE_SAMPLES = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_STEREO   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO_OUT      = 3'd6;

   // Envelope unity in Q1.23
   localparam logic [23:0] ENV_UNITY = 24'h800000;

   typedef struct packed {
      logic [1:0]                     cmd;
      logic [15:0]                    sample_index;
      logic signed [SAMPLE_BITS-1:0]  left_sample;
      logic signed [SAMPLE_BITS-1:0]  right_sample;
      logic [6:0]                     note;
      logic [15:0]                    velocity;
      logic                           allow_tail;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0]  left_out;
      logic signed [SAMPLE_BITS-1:0]  right_out;
      logic                           sounding;
      logic                           still_active;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic load_wr;
      logic note_off;
      logic note_mul;
      logic note_step;
      logic div_start;
      logic slope_load;
      logic tick_addr;
      logic rd0;
      logic rd1;
      logic mul;
      logic gain;
      logic env;
      logic fin;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_busy;
      logic out_free;
   } dp_stat_type;

   // Equal-tempered semitone ratios, Q16.16
   function automatic logic [16:0] semitone(input logic [3:0] s);
      logic [16:0] v;
      case (s)
         4'd0:    v = 17'd65536;
         4'd1:    v = 17'd69433;
         4'd2:    v = 17'd73562;
         4'd3:    v = 17'd77936;
         4'd4:    v = 17'd82570;
         4'd5:    v = 17'd87480;
         4'd6:    v = 17'd92682;
         4'd7:    v = 17'd98193;
         4'd8:    v = 17'd104032;
         4'd9:    v = 17'd110218;
         4'd10:   v = 17'd116772;
         4'd11:   v = 17'd123715;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[rtl/spv_ram.sv]
`default_nettype none
module spv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[rtl/spv_div.sv]
`default_nettype none
module spv_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [39:0] num,
   input  wire logic [23:0] den,
   output logic             busy,
   output logic [23:0]      quo
);

   // Restoring division, one quotient bit a cycle, saturating at 24 bits
   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [23:0] rem_ff, rem_in;
   logic [23:0] lo_ff, lo_in;
   logic [23:0] den_ff, den_in;
   logic [23:0] quo_ff, quo_in;
   logic [24:0] trial;
   logic        ge;
   logic        too_big;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, lo_ff[23]};
      ge      = trial >= {1'b0, den_ff};
      too_big = {8'd0, num} >= {den, 24'd0};
      if (start) begin
         den_in = den;
         cnt_in = 5'd0;
         rem_in = {8'd0, num[39:24]};
         lo_in  = num[23:0];
         quo_in = 24'd0;
         if (den == 24'd0) begin
            busy_in = 1'b0;
         end else if (too_big) begin
            quo_in  = 24'hFFFFFF;
            busy_in = 1'b0;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = ge ? 24'(trial - {1'b0, den_ff}) : trial[23:0];
         quo_in = {quo_ff[22:0], ge};
         lo_in  = {lo_ff[22:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd23) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

[rtl/spv_ctrl.sv]
`default_nettype none
module spv_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_cmd,
   output logic                      req_stall,
   input  wire spv_pkg::dp_stat_type stat,
   output spv_pkg::dp_cmd_type       cmd
);

   typedef enum logic [11:0] {
      S_IDLE      = 12'b000000000001,
      S_NOTE_MUL  = 12'b000000000010,
      S_NOTE_STEP = 12'b000000000100,
      S_NOTE_DIV  = 12'b000000001000,
      S_NOTE_WAIT = 12'b000000010000,
      S_ADDR      = 12'b000000100000,
      S_RD0       = 12'b000001000000,
      S_RD1       = 12'b000010000000,
      S_MUL       = 12'b000100000000,
      S_GAIN      = 12'b001000000000,
      S_ENV       = 12'b010000000000,
      S_FIN       = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_cmd == spv_pkg::CMD_NOTE_ON) begin
               state_in = S_NOTE_MUL;
            end else if (accept && req_cmd == spv_pkg::CMD_TICK) begin
               state_in = S_ADDR;
            end
         end
         S_NOTE_MUL:  state_in = S_NOTE_STEP;
         S_NOTE_STEP: state_in = S_NOTE_DIV;
         S_NOTE_DIV:  state_in = S_NOTE_WAIT;
         S_NOTE_WAIT: begin
            if (!stat.div_busy) begin
               state_in = S_IDLE;
            end
         end
         S_ADDR: state_in = S_RD0;
         S_RD0:  state_in = S_RD1;
         S_RD1:  state_in = S_MUL;
         S_MUL:  state_in = S_GAIN;
         S_GAIN: state_in = S_ENV;
         S_ENV:  state_in = S_FIN;
         S_FIN: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd            = '0;
      cmd.capture    = accept;
      cmd.load_wr    = accept && req_cmd == spv_pkg::CMD_LOAD;
      cmd.note_off   = accept && req_cmd == spv_pkg::CMD_NOTE_OFF;
      cmd.note_mul   = (state_ff == S_NOTE_MUL);
      cmd.note_step  = (state_ff == S_NOTE_STEP);
      cmd.div_start  = (state_ff == S_NOTE_DIV);
      cmd.slope_load = (state_ff == S_NOTE_WAIT) && !stat.div_busy;
      cmd.tick_addr  = (state_ff == S_ADDR);
      cmd.rd0        = (state_ff == S_RD0);
      cmd.rd1        = (state_ff == S_RD1);
      cmd.mul        = (state_ff == S_MUL);
      cmd.gain       = (state_ff == S_GAIN);
      cmd.env        = (state_ff == S_ENV);
      cmd.fin        = (state_ff == S_FIN) && stat.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == spv_pkg::CMD_TICK) |=> state_ff == S_ADDR)
      else $error("tick item did not start the tick sequence");

   a_div_in_wait: assert property (@(posedge clock) disable iff (reset)
      stat.div_busy |-> state_ff == S_NOTE_WAIT)
      else $error("divider busy outside the slope wait");

endmodule
`default_nettype wire

[rtl/spv_dpath.sv]
`default_nettype none
module spv_dpath #(
   parameter int SAMPLE_DEPTH = 65536
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire spv_pkg::req_type                  req_data,
   input  wire logic                              csr_we,
   input  wire logic [spv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [spv_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire spv_pkg::dp_cmd_type               cmd,
   output spv_pkg::dp_stat_type                   stat,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output spv_pkg::rsp_type                       rsp_data
);

   localparam int SB = spv_pkg::SAMPLE_BITS;
   localparam int AW = $clog2(SAMPLE_DEPTH);
   localparam logic [28:0] DEPTH_W = 29'(SAMPLE_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(SAMPLE_DEPTH - 1);
   localparam logic signed [SB+3:0] SAT_HI = (SB+4)'((1 <<< (SB - 1)) - 1);
   localparam logic signed [SB+3:0] SAT_LO = ~SAT_HI;

   // Address modulo the store depth: quotient is below 256, one bit a step
   function automatic logic [AW-1:0] wrap_addr(input logic [15:0] x);
      logic [28:0] r;
      r = 29'(x);
      for (int k = 7; k >= 0; k--) begin
         if (r >= (DEPTH_W << k)) begin
            r = r - (DEPTH_W << k);
         end
      end
      return r[AW-1:0];
   endfunction

   function automatic logic [SB-1:0] sat_out(input logic signed [SB+3:0] v);
      logic [SB-1:0] s;
      if (v > SAT_HI) begin
         s = SAT_HI[SB-1:0];
      end else if (v < SAT_LO) begin
         s = SAT_LO[SB-1:0];
      end else begin
         s = v[SB-1:0];
      end
      return s;
   endfunction

   // Configuration registers
   logic [6:0]  root_ff;
   logic [19:0] ratio_ff;
   logic [15:0] length_ff;
   logic [23:0] atk_cnt_ff;
   logic [23:0] rel_cnt_ff;
   logic        src_st_ff;
   logic        out_st_ff;

   // Voice state
   logic [31:0] phase_ff, phase_in;
   logic [31:0] step_ff, step_in;
   logic [15:0] gain_ff, gain_in;
   logic [23:0] env_ff, env_in;
   logic [23:0] atk_slope_ff, atk_slope_in;
   logic [23:0] rel_slope_ff, rel_slope_in;
   logic        in_atk_ff, in_atk_in;
   logic        in_rel_ff, in_rel_in;
   logic        active_ff, active_in;

   // Work registers
   spv_pkg::req_type req_q_ff;
   logic [36:0]           prod_ff, prod_in;
   logic [4:0]            sh_ff, sh_in;
   logic [AW-1:0]         a0_ff, a1_ff;
   logic signed [SB-1:0]  s0l_ff, s0r_ff;
   logic signed [SB+17:0] pl_ff, pr_ff;
   logic signed [SB+16:0] gl_ff, gr_ff;
   logic signed [SB+1:0]  lg_ff, rg_ff;
   logic signed [SB+26:0] el_ff, er_ff;
   spv_pkg::rsp_type      rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Sample store
   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [SB-1:0] l_rdata, r_rdata;

   assign ram_we   = cmd.load_wr;
   assign ram_addr = cmd.load_wr ? wrap_addr(req_data.sample_index) :
                     (cmd.rd0 ? a0_ff : a1_ff);

   spv_ram #(.WIDTH(SB), .DEPTH(SAMPLE_DEPTH)) u_left_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (SB'($unsigned(req_data.left_sample))),
      .rdata (l_rdata)
   );

   spv_ram #(.WIDTH(SB), .DEPTH(SAMPLE_DEPTH)) u_right_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (SB'($unsigned(req_data.right_sample))),
      .rdata (r_rdata)
   );

   // Slope dividers, attack and release in parallel
   logic        atk_busy, rel_busy;
   logic [23:0] atk_quo, rel_quo;
   logic [39:0] atk_num, rel_num;

   assign atk_num = {1'b0, step_ff, 7'd0} + 40'(atk_cnt_ff >> 1);
   assign rel_num = {1'b0, step_ff, 7'd0} + 40'(rel_cnt_ff >> 1);

   spv_div u_atk_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (atk_num),
      .den   (atk_cnt_ff),
      .busy  (atk_busy),
      .quo   (atk_quo)
   );

   spv_div u_rel_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (rel_num),
      .den   (rel_cnt_ff),
      .busy  (rel_busy),
      .quo   (rel_quo)
   );

   assign stat.div_busy = atk_busy || rel_busy;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   // Note on: octave and semitone of the note distance, then pitch product
   logic [8:0]  note_dst;
   logic [8:0]  drem;
   logic [4:0]  octq;
   logic [37:0] rnd;
   logic [37:0] step_full;

   always_comb begin
      note_dst = 9'({2'd0, req_q_ff.note}) - 9'({2'd0, root_ff}) + 9'd132;
      drem = note_dst;
      octq = 5'd0;
      for (int k = 4; k >= 0; k--) begin
         if (drem >= (9'd12 << k)) begin
            drem    = drem - (9'd12 << k);
            octq[k] = 1'b1;
         end
      end
      prod_in   = 37'(spv_pkg::semitone(drem[3:0])) * 37'(ratio_ff);
      sh_in     = 5'd27 - octq;
      rnd       = {1'b0, prod_ff} + (38'd1 << (sh_ff - 5'd1));
      step_full = rnd >> sh_ff;
   end

   // Tick arithmetic lanes
   logic [15:0]           frac;
   logic signed [SB-1:0]  s1l, s1r;
   logic signed [SB+17:0] dl, dr, fx;
   logic signed [SB+17:0] suml, sumr;
   logic signed [SB-1:0]  il, ir;
   logic signed [SB+16:0] gx;
   logic signed [SB+26:0] ex;
   logic signed [SB+3:0]  lf, rf;
   logic signed [SB+4:0]  msum;
   logic                  use_env;

   always_comb begin
      frac = phase_ff[15:0];
      s1l  = $signed(l_rdata);
      s1r  = src_st_ff ? $signed(r_rdata) : $signed(l_rdata);
      fx   = $signed((SB+18)'(frac));
      dl   = (SB+18)'(s1l) - (SB+18)'(s0l_ff);
      dr   = (SB+18)'(s1r) - (SB+18)'(s0r_ff);
      // s0 + (s1 - s0) * frac, floored at 16 bits
      suml = ((SB+18)'(s0l_ff) <<< 16) + pl_ff;
      sumr = ((SB+18)'(s0r_ff) <<< 16) + pr_ff;
      il   = $signed(suml[SB+15:16]);
      ir   = $signed(sumr[SB+15:16]);
      gx   = $signed((SB+17)'(gain_ff));
      ex   = $signed((SB+27)'(env_ff));
      use_env = in_atk_ff || in_rel_ff;
      lf   = use_env ? $signed(el_ff[SB+26:23]) : (SB+4)'(lg_ff);
      rf   = use_env ? $signed(er_ff[SB+26:23]) : (SB+4)'(rg_ff);
      msum = (SB+5)'(lf) + (SB+5)'(rf);
   end

   // Voice state update and result
   logic [32:0] phase_nxt;
   logic [24:0] atk_lv;
   logic        past_end;

   always_comb begin
      phase_in     = phase_ff;
      step_in      = step_ff;
      gain_in      = gain_ff;
      env_in       = env_ff;
      atk_slope_in = atk_slope_ff;
      rel_slope_in = rel_slope_ff;
      in_atk_in    = in_atk_ff;
      in_rel_in    = in_rel_ff;
      active_in    = active_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      phase_nxt    = {1'b0, phase_ff} + {1'b0, step_ff};
      past_end     = phase_nxt > {1'b0, length_ff, 16'd0};
      atk_lv       = {1'b0, env_ff} + {1'b0, atk_slope_ff};

      if (cmd.note_off) begin
         if (req_data.allow_tail) begin
            in_atk_in = 1'b0;
            in_rel_in = 1'b1;
         end else begin
            active_in = 1'b0;
         end
      end

      if (cmd.note_step) begin
         step_in   = step_full[31:0];
         phase_in  = 32'd0;
         gain_in   = req_q_ff.velocity;
         in_atk_in = (atk_cnt_ff != 24'd0);
         in_rel_in = 1'b0;
         env_in    = (atk_cnt_ff != 24'd0) ? 24'd0 : spv_pkg::ENV_UNITY;
         active_in = 1'b1;
      end

      if (cmd.slope_load) begin
         atk_slope_in = atk_quo;
         rel_slope_in = rel_quo;
      end

      if (cmd.fin) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (!active_ff) begin
            // idle voice: silent result
         end else if (in_rel_ff && !in_atk_ff && rel_slope_ff >= env_ff) begin
            // release ran out: silent, voice stops
            env_in    = 24'd0;
            active_in = 1'b0;
         end else begin
            if (in_atk_ff) begin
               if (atk_lv >= {1'b0, spv_pkg::ENV_UNITY}) begin
                  env_in    = spv_pkg::ENV_UNITY;
                  in_atk_in = 1'b0;
               end else begin
                  env_in = atk_lv[23:0];
               end
            end else if (in_rel_ff) begin
               env_in = env_ff - rel_slope_ff;
            end
            if (out_st_ff) begin
               rsp_in.left_out  = $signed(sat_out(lf));
               rsp_in.right_out = $signed(sat_out(rf));
            end else begin
               rsp_in.left_out  = $signed(sat_out($signed(msum[SB+4:1])));
            end
            rsp_in.sounding     = 1'b1;
            phase_in            = phase_nxt[31:0];
            active_in           = !past_end;
            rsp_in.still_active = !past_end;
         end
      end
   end

   // Control and voice state
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff      <= 7'd60;
         ratio_ff     <= 20'd65536;
         length_ff    <= 16'd0;
         atk_cnt_ff   <= 24'd0;
         rel_cnt_ff   <= 24'd0;
         src_st_ff    <= 1'b1;
         out_st_ff    <= 1'b1;
         phase_ff     <= 32'd0;
         step_ff      <= 32'd0;
         gain_ff      <= 16'd0;
         env_ff       <= 24'd0;
         atk_slope_ff <= 24'd0;
         rel_slope_ff <= 24'd0;
         in_atk_ff    <= 1'b0;
         in_rel_ff    <= 1'b0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               spv_pkg::CSR_ROOT_NOTE:       root_ff    <= csr_wdata[6:0];
               spv_pkg::CSR_RATE_RATIO:      ratio_ff   <= csr_wdata[19:0];
               spv_pkg::CSR_SAMPLE_LENGTH:   length_ff  <= csr_wdata[15:0];
               spv_pkg::CSR_ATTACK_SAMPLES:  atk_cnt_ff <= csr_wdata;
               spv_pkg::CSR_RELEASE_SAMPLES: rel_cnt_ff <= csr_wdata;
               spv_pkg::CSR_SOURCE_STEREO:   src_st_ff  <= csr_wdata[0];
               spv_pkg::CSR_STEREO_OUT:      out_st_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         gain_ff      <= gain_in;
         env_ff       <= env_in;
         atk_slope_ff <= atk_slope_in;
         rel_slope_ff <= rel_slope_in;
         in_atk_ff    <= in_atk_in;
         in_rel_ff    <= in_rel_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and pipeline registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.capture) begin
         req_q_ff <= req_data;
      end
      if (cmd.note_mul) begin
         prod_ff <= prod_in;
         sh_ff   <= sh_in;
      end
      if (cmd.tick_addr) begin
         a0_ff <= wrap_addr(phase_ff[31:16]);
         a1_ff <= (wrap_addr(phase_ff[31:16]) == LAST_ADDR) ? '0 :
                  wrap_addr(phase_ff[31:16]) + AW'(1);
      end
      if (cmd.rd1) begin
         s0l_ff <= $signed(l_rdata);
         s0r_ff <= src_st_ff ? $signed(r_rdata) : $signed(l_rdata);
      end
      if (cmd.mul) begin
         pl_ff <= dl * fx;
         pr_ff <= dr * fx;
      end
      if (cmd.gain) begin
         gl_ff <= (SB+17)'(il) * gx;
         gr_ff <= (SB+17)'(ir) * gx;
      end
      if (cmd.env) begin
         lg_ff <= $signed(gl_ff[SB+16:15]);
         rg_ff <= $signed(gr_ff[SB+16:15]);
         el_ff <= (SB+27)'($signed(gl_ff[SB+16:15])) * ex;
         er_ff <= (SB+27)'($signed(gr_ff[SB+16:15])) * ex;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_env_bounded: assert property (@(posedge clock) disable iff (reset)
      env_ff <= spv_pkg::ENV_UNITY)
      else $error("envelope above unity");

   a_phase_flags: assert property (@(posedge clock) disable iff (reset)
      !(in_atk_ff && in_rel_ff))
      else $error("attack and release both set");

   a_out_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> !(rsp_valid_ff && rsp_stall))
      else $error("result written over a stalled result");

endmodule
`default_nettype wire

[rtl/sample_playback_voice_unit.sv]
`default_nettype none
// Channel  | Handshake                 | Payload
// req      | req_valid / req_stall     | req_data  (spv_pkg::req_type)
// rsp      | rsp_valid / rsp_stall     | rsp_data  (spv_pkg::rsp_type)
// csr      | csr_valid / csr_ready     | csr_index, csr_wdata
//
// Load and note-off items finish on acceptance. A tick steps through address,
// two store reads on the single RAM port, then interpolate, gain and envelope
// multiplies, each registered. A note-on runs pitch multiply, step update and
// the 24-step slope dividers, skipped when neither slope needs a division. Reset
// is synchronous; the sample store is not cleared and reads back undefined until
// written. The result register lets the next item in while a result waits; a
// tick stalls in its last step only when the previous result is still not taken.
module sample_playback_voice_unit #(
   parameter int SAMPLE_DEPTH = 65536
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire spv_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output spv_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [spv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [spv_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   spv_pkg::dp_cmd_type  cmd;
   spv_pkg::dp_stat_type stat;

   assign csr_ready = 1'b1;

   spv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   spv_dpath #(
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[sim/tb_top.sv]
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 48;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   spv_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   spv_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [spv_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [spv_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   sample_playback_voice_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // voice copy: registers, store and playback state
   logic [6:0]  v_root = 7'd60;
   logic [19:0] v_rate = 20'd65536;
   logic [15:0] v_length = '0;
   logic [23:0] v_attack_len = '0, v_release_len = '0;
   logic        v_src_stereo = 1'b1, v_stereo_out = 1'b1;
   logic signed [15:0] left_mem [0:65535];
   logic signed [15:0] right_mem [0:65535];
   bit          loaded [0:65535];
   logic [31:0] v_phase = '0, v_step = '0;
   logic [15:0] v_gain = '0;
   logic [23:0] v_env = '0, v_attack_slope = '0, v_release_slope = '0;
   logic        v_in_attack = 0, v_in_release = 0, v_active = 0;

   spv_pkg::rsp_type expected_tick_q [$];
   int      mismatches = 0;
   int      items_sent = 0;
   int      idle_pct = 0;
   int      stall_pct = 0;
   int      quiet_cycles = 0;

   function automatic logic [16:0] semi_ratio(input int s);
      logic [16:0] tab [0:11];
      tab = '{17'd65536, 17'd69433, 17'd73562, 17'd77936, 17'd82570, 17'd87480,
              17'd92682, 17'd98193, 17'd104032, 17'd110218, 17'd116772, 17'd123715};
      return tab[s];
   endfunction

   function automatic logic [23:0] slope_of(input logic [31:0] stp, input logic [23:0] cnt);
      longint unsigned q;
      if (cnt == 0) return '0;
      q = ((longint'(stp) << 7) + (cnt >> 1)) / cnt;
      return (q > 64'hFFFFFF) ? 24'hFFFFFF : q[23:0];
   endfunction

   function automatic logic [15:0] clip16(input longint v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   // work out the effect of one accepted item on the voice
   task automatic voice_apply(input spv_pkg::req_type it);
      int d, octave, semi, sh;
      longint unsigned prod, stp, nxt;
      longint l, r, s0, s1;
      logic [15:0] pos, a1, frac;
      logic [24:0] lv;
      spv_pkg::rsp_type res;
      case (it.cmd)
         spv_pkg::CMD_LOAD: begin
            left_mem[it.sample_index] = it.left_sample;
            right_mem[it.sample_index] = it.right_sample;
            loaded[it.sample_index] = 1;
         end
         spv_pkg::CMD_NOTE_ON: begin
            d = int'(it.note) - int'(v_root) + 132;
            octave = d / 12 - 11;
            semi = d % 12;
            sh = 16 - octave;
            prod = longint'(semi_ratio(semi)) * longint'(v_rate);
            stp = (prod + (64'd1 << (sh - 1))) >> sh;
            v_step = (stp > 64'hFFFFFFFF) ? 32'hFFFFFFFF : stp[31:0];
            v_phase = '0;
            v_gain = it.velocity;
            v_in_attack = (v_attack_len != 0);
            v_in_release = 0;
            v_env = v_in_attack ? 24'd0 : spv_pkg::ENV_UNITY;
            v_attack_slope = slope_of(v_step, v_attack_len);
            v_release_slope = slope_of(v_step, v_release_len);
            v_active = 1;
         end
         spv_pkg::CMD_NOTE_OFF: begin
            if (it.allow_tail) begin
               v_in_attack = 0;
               v_in_release = 1;
            end else begin
               v_active = 0;
            end
         end
         default: begin
            res = '0;
            if (v_active) begin
               pos = v_phase[31:16];
               a1 = pos + 16'd1;
               frac = v_phase[15:0];
               s0 = left_mem[pos];
               s1 = left_mem[a1];
               l = (s0 * (65536 - longint'(frac)) + s1 * longint'(frac)) >>> 16;
               if (v_src_stereo) begin
                  s0 = right_mem[pos];
                  s1 = right_mem[a1];
                  r = (s0 * (65536 - longint'(frac)) + s1 * longint'(frac)) >>> 16;
               end else begin
                  r = l;
               end
               l = (l * longint'(v_gain)) >>> 15;
               r = (r * longint'(v_gain)) >>> 15;
               res.sounding = 1;
               if (v_in_attack) begin
                  l = (l * longint'(v_env)) >>> 23;
                  r = (r * longint'(v_env)) >>> 23;
                  lv = v_env + v_attack_slope;
                  if (lv >= spv_pkg::ENV_UNITY) begin
                     lv = spv_pkg::ENV_UNITY;
                     v_in_attack = 0;
                  end
                  v_env = lv[23:0];
               end else if (v_in_release) begin
                  l = (l * longint'(v_env)) >>> 23;
                  r = (r * longint'(v_env)) >>> 23;
                  if (v_release_slope >= v_env) begin
                     // release ran out: silent tick and the voice stops
                     v_env = '0;
                     v_active = 0;
                     res.sounding = 0;
                  end else begin
                     v_env = v_env - v_release_slope;
                  end
               end
               if (res.sounding) begin
                  if (v_stereo_out) begin
                     res.left_out = clip16(l);
                     res.right_out = clip16(r);
                  end else begin
                     res.left_out = clip16((l + r) >>> 1);
                  end
                  nxt = longint'(v_phase) + longint'(v_step);
                  v_phase = nxt[31:0];
                  if (nxt > (longint'(v_length) << 16)) v_active = 0;
                  res.still_active = v_active;
               end
            end
            expected_tick_q.push_back(res);
         end
      endcase
   endtask

   // one item on the request channel; valid stays up if the next follows at once
   task automatic send_item(input spv_pkg::req_type it);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      voice_apply(it);
      items_sent++;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic send_load(input logic [15:0] addr, input logic [15:0] lval,
                            input logic [15:0] rval);
      spv_pkg::req_type it;
      it = spv_pkg::req_type'({$urandom(), $urandom(), $urandom()});
      it.cmd = spv_pkg::CMD_LOAD;
      it.sample_index = addr;
      it.left_sample = lval;
      it.right_sample = rval;
      send_item(it);
   endtask

   task automatic send_note_on(input logic [6:0] nt, input logic [15:0] vel);
      spv_pkg::req_type it;
      it = spv_pkg::req_type'({$urandom(), $urandom(), $urandom()});
      it.cmd = spv_pkg::CMD_NOTE_ON;
      it.note = nt;
      it.velocity = vel;
      send_item(it);
   endtask

   task automatic send_note_off(input logic tail);
      spv_pkg::req_type it;
      it = spv_pkg::req_type'({$urandom(), $urandom(), $urandom()});
      it.cmd = spv_pkg::CMD_NOTE_OFF;
      it.allow_tail = tail;
      send_item(it);
   endtask

   // a tick on an active voice never reads a store entry that has not been loaded
   task automatic send_tick();
      spv_pkg::req_type it;
      logic [15:0] pos;
      if (v_active) begin
         pos = v_phase[31:16];
         if (!loaded[pos]) send_load(pos, 16'($urandom()), 16'($urandom()));
         if (!loaded[pos + 16'd1])
            send_load(pos + 16'd1, 16'($urandom()), 16'($urandom()));
      end
      it = spv_pkg::req_type'({$urandom(), $urandom(), $urandom()});
      it.cmd = spv_pkg::CMD_TICK;
      send_item(it);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_tick_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [spv_pkg::CSR_IDX_W-1:0] idx,
                            input logic [spv_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         spv_pkg::CSR_ROOT_NOTE:       v_root = val[6:0];
         spv_pkg::CSR_RATE_RATIO:      v_rate = val[19:0];
         spv_pkg::CSR_SAMPLE_LENGTH:   v_length = val[15:0];
         spv_pkg::CSR_ATTACK_SAMPLES:  v_attack_len = val;
         spv_pkg::CSR_RELEASE_SAMPLES: v_release_len = val;
         spv_pkg::CSR_SOURCE_STEREO:   v_src_stereo = val[0];
         spv_pkg::CSR_STEREO_OUT:      v_stereo_out = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // 0: musical random setting, 1: all registers low, 2: all registers high
   task automatic configure(input int kind);
      wait_idle();
      if (kind == 1) begin
         write_reg(spv_pkg::CSR_ROOT_NOTE, 24'd0);
         write_reg(spv_pkg::CSR_RATE_RATIO, 24'd0);
         write_reg(spv_pkg::CSR_SAMPLE_LENGTH, 24'd0);
         write_reg(spv_pkg::CSR_ATTACK_SAMPLES, 24'd0);
         write_reg(spv_pkg::CSR_RELEASE_SAMPLES, 24'd0);
         write_reg(spv_pkg::CSR_SOURCE_STEREO, 24'd0);
         write_reg(spv_pkg::CSR_STEREO_OUT, 24'd0);
      end else if (kind == 2) begin
         write_reg(spv_pkg::CSR_ROOT_NOTE, 24'd127);
         write_reg(spv_pkg::CSR_RATE_RATIO, 24'hFFFFF);
         write_reg(spv_pkg::CSR_SAMPLE_LENGTH, 24'd65532);
         write_reg(spv_pkg::CSR_ATTACK_SAMPLES, 24'hFFFFFF);
         write_reg(spv_pkg::CSR_RELEASE_SAMPLES, 24'hFFFFFF);
         write_reg(spv_pkg::CSR_SOURCE_STEREO, 24'd1);
         write_reg(spv_pkg::CSR_STEREO_OUT, 24'd1);
      end else begin
         write_reg(spv_pkg::CSR_ROOT_NOTE, 24'($urandom_range(72, 48)));
         write_reg(spv_pkg::CSR_RATE_RATIO, 24'($urandom_range(131072, 32768)));
         write_reg(spv_pkg::CSR_SAMPLE_LENGTH, 24'($urandom_range(48, 4)));
         write_reg(spv_pkg::CSR_ATTACK_SAMPLES,
                   24'(($urandom_range(2) == 0) ? 0 : $urandom_range(40, 1)));
         write_reg(spv_pkg::CSR_RELEASE_SAMPLES,
                   24'(($urandom_range(3) == 0) ? 0 : $urandom_range(40, 1)));
         write_reg(spv_pkg::CSR_SOURCE_STEREO, 24'($urandom_range(1)));
         write_reg(spv_pkg::CSR_STEREO_OUT, 24'($urandom_range(1)));
      end
   endtask

   task automatic report_mismatch(input string what, input spv_pkg::rsp_type got,
                                  input spv_pkg::rsp_type exp);
      mismatches++;
      $display("mismatch %s: got l=%0d r=%0d s=%0b a=%0b exp l=%0d r=%0d s=%0b a=%0b",
               what, got.left_out, got.right_out, got.sounding, got.still_active,
               exp.left_out, exp.right_out, exp.sounding, exp.still_active);
   endtask

   // result checker
   always @(posedge clock) begin
      spv_pkg::rsp_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tick_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_data, '0);
         end else begin
            exp = expected_tick_q.pop_front();
            if (rsp_data.left_out !== exp.left_out)
               report_mismatch("left_out", rsp_data, exp);
            if (rsp_data.right_out !== exp.right_out)
               report_mismatch("right_out", rsp_data, exp);
            if (rsp_data.sounding !== exp.sounding)
               report_mismatch("sounding", rsp_data, exp);
            if (rsp_data.still_active !== exp.still_active)
               report_mismatch("still_active", rsp_data, exp);
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog on handshake progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[sample_playback_voice_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // extremes of the fields and the named corner cases
   task automatic test_directed();
      int k;
      send_tick();                       // idle voice gives a zero result
      send_note_off(1'b1);               // tail while idle only flags release
      send_tick();
      for (k = 0; k < 6; k++) send_load(16'(k), (k[0]) ? 16'h7FFF : 16'h8000,
                                        (k[0]) ? 16'h8000 : 16'h7FFF);
      send_load(16'hFFFF, 16'h8000, 16'h7FFF);
      configure(0);
      write_reg(spv_pkg::CSR_SAMPLE_LENGTH, 24'd4);
      write_reg(spv_pkg::CSR_ATTACK_SAMPLES, 24'd0);
      write_reg(spv_pkg::CSR_RELEASE_SAMPLES, 24'd0);
      send_note_on(v_root, 16'd32768);   // unity gain at root pitch
      send_tick();
      send_tick();
      send_note_on(7'd127, 16'd32768);   // highest note at unity gain
      send_tick();
      send_note_off(1'b0);               // immediate stop
      send_tick();
      configure(2);
      send_note_on(7'd127, 16'd0);
      send_tick();
      send_note_off(1'b1);
      send_tick();
      configure(1);
      send_note_on(7'd0, 16'd32768);
      send_tick();
      send_tick();
      send_note_off(1'b1);               // release of zero never fades
      send_tick();
   endtask

   // well-formed notes with random content plus some stray items
   task automatic test_random(input int budget);
      int stop_at, n, k;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         if ((items_sent % 90) < 2)
            configure(int'(($urandom_range(9) == 0) ? $urandom_range(2, 1) : 0));
         case ($urandom_range(9))
            0: send_note_off($urandom_range(1) != 0);
            1: send_tick();
            2: send_load(16'($urandom()), 16'($urandom()), 16'($urandom()));
            default: begin
               n = $urandom_range(4);
               for (k = 0; k < n; k++)
                  send_load(16'($urandom_range(v_length + 2)), 16'($urandom()),
                            16'($urandom()));
               send_note_on(7'(($urandom_range(4) == 0) ? $urandom_range(127) :
                               $urandom_range(v_root + 12 > 127 ? 127 : v_root + 12,
                                              v_root < 12 ? 0 : v_root - 12)),
                            16'($urandom_range(32768)));
               n = $urandom_range(24, 1);
               for (k = 0; k < n; k++) send_tick();
               if ($urandom_range(3) != 0) send_note_off($urandom_range(3) != 0);
               n = $urandom_range(12);
               for (k = 0; k < n; k++) send_tick();
            end
         endcase
      end
   endtask

   task automatic test_idle_mix();
      idle_pct = 0;  stall_pct = 0;  test_random(290);
      idle_pct = 60; stall_pct = 0;  test_random(280);
      idle_pct = 0;  stall_pct = 60; test_random(280);
      idle_pct = 12; stall_pct = 12; test_random(280);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_idle_mix();
      wait_idle();
      if (mismatches == 0 && expected_tick_q.size() == 0) begin
         $display("[sample_playback_voice_unit] OK");
      end else begin
         $display("[sample_playback_voice_unit] ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

[files.f]
rtl/spv_pkg.sv
rtl/spv_ram.sv
rtl/spv_div.sv
rtl/spv_ctrl.sv
rtl/spv_dpath.sv
rtl/sample_playback_voice_unit.sv
sim/tb_top.sv
